FILE: rtl/sd_card_init_and_transfer_sequencer_top_defines.svh
// Assertion macros for the SD command sequencer.
// Used by the top level only; no other dependencies.
`ifndef SD_CARD_INIT_AND_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`define SD_CARD_INIT_AND_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SDCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdcs assertion failed");
`define SDCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdcs assertion failed");
`else
`define SDCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sdcs_pkg.sv
// Types and constants shared by the SD command sequencer.
// No dependencies.
package sdcs_pkg;

    localparam int unsigned BLOCK_BYTES = 512;

    localparam logic [3:0]  FLAGS_NONE  = 4'd0;
    localparam logic [3:0]  FLAGS_SHORT = 4'd5;
    localparam logic [3:0]  FLAGS_LONG  = 4'd7;
    localparam logic [3:0]  FLAGS_BUSY  = 4'd13;
    localparam logic [31:0] CMD8_ARG    = 32'h0000_0155;
    localparam logic [31:0] ACMD41_ARG  = 32'h40ff_8000;
    localparam logic [31:0] SWITCH_ARG  = 32'h00ff_ff01;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_WRITE = 2'd3;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    localparam logic [1:0] CLK_KEEP = 2'd0;
    localparam logic [1:0] CLK_ID   = 2'd1;
    localparam logic [1:0] CLK_HS   = 2'd2;

    localparam logic [1:0] STAT_CMD  = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    localparam logic [1:0] CARD_NONE = 2'd0;
    localparam logic [1:0] CARD_SDSC = 2'd1;
    localparam logic [1:0] CARD_SDHC = 2'd2;

    typedef enum logic [5:0] {
        PH_IDLE, PH_C0, PH_C8, PH_H55, PH_H41, PH_L0, PH_L55, PH_L41, PH_LL55,
        PH_CID, PH_RCA, PH_CSD, PH_SEL, PH_SCR55, PH_SCR, PH_SW, PH_W55, PH_W6,
        PH_BLEN, PH_DESEL, PH_READY, PH_RSEL, PH_XFER, PH_RDESEL
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic        cmd_ok;
        logic [31:0] resp_word1;
        logic [31:0] resp_word2;
        logic [31:0] resp_word3;
        logic [31:0] data_first_word;
        logic [31:0] data_eighth_word;
        logic [31:0] sector;
        logic [15:0] block_count;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [3:0]  resp_flags;
        logic [1:0]  data_dir;
        logic [15:0] xfer_blocks;
        logic [9:0]  xfer_block_size;
        logic [1:0]  clock_choice;
        logic        bus_width_four;
        logic [1:0]  seq_status;
        logic [1:0]  card_kind;
        logic [31:0] sector_total;
    } t_out_item;

endpackage

FILE: rtl/sdcs_if.sv
// Channel interfaces of the SD command sequencer: event input, command
// output and configuration write. Depends on nothing.
interface sdcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        cmd_ok;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic [31:0] data_first_word;
    logic [31:0] data_eighth_word;
    logic [31:0] sector;
    logic [15:0] block_count;
    modport source (output valid, kind, cmd_ok, resp_word0, resp_word1, resp_word2,
                    resp_word3, data_first_word, data_eighth_word, sector,
                    block_count, input ready);
    modport sink (input valid, kind, cmd_ok, resp_word0, resp_word1, resp_word2,
                  resp_word3, data_first_word, data_eighth_word, sector,
                  block_count, output ready);
endinterface

interface sdcs_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [3:0]  resp_flags;
    logic [1:0]  data_dir;
    logic [15:0] xfer_blocks;
    logic [9:0]  xfer_block_size;
    logic [1:0]  clock_choice;
    logic        bus_width_four;
    logic [1:0]  seq_status;
    logic [1:0]  card_kind;
    logic [31:0] sector_total;
    modport source (output valid, cmd_index, cmd_argument, resp_flags, data_dir,
                    xfer_blocks, xfer_block_size, clock_choice, bus_width_four,
                    seq_status, card_kind, sector_total, input ready);
    modport sink (input valid, cmd_index, cmd_argument, resp_flags, data_dir,
                  xfer_blocks, xfer_block_size, clock_choice, bus_width_four,
                  seq_status, card_kind, sector_total, output ready);
endinterface

interface sdcs_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/sd_card_init_and_transfer_sequencer_top.sv
// Top level of the SD command sequencer: input register, decision core,
// result register. Depends on sdcs_pkg, sdcs_if, sdcs_core and the defines.
//
// Use: i_in carries events (start, command completion with status and
// response/data words, read or write request); o_out carries the next
// command to issue or a done/failed status. i_cfg writes wide_bus_enable
// (reset 1) and is always ready; write it only while the block is idle.
// Path: input register, core, result register. Throughput: one event per
// cycle while the result register is empty or o_out.ready is high; the limit
// is the single state update between input register and result register.
// A completion while idle or ready gives no result.
// Reset: phase idle, no card, 1-bit bus, result register empty.
// Stall: a result held by a low o_out.ready keeps its value; one more
// event may sit in the input register, then i_in.ready drops.
`include "sd_card_init_and_transfer_sequencer_top_defines.svh"
module sd_card_init_and_transfer_sequencer_top
    import sdcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdcs_in_if.sink     i_in,
    sdcs_out_if.source  o_out,
    sdcs_cfg_if.sink    i_cfg
);

    logic      r_wide_en;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_adv;
    logic      w_emit;
    t_out_item w_res;

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_en <= 1'b1;
        end else if (i_cfg.valid) begin
            r_wide_en <= i_cfg.data;
        end
    end

    // Input register
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.kind             <= i_in.kind;
            r_in.cmd_ok           <= i_in.cmd_ok;
            r_in.resp_word1       <= i_in.resp_word1;
            r_in.resp_word2       <= i_in.resp_word2;
            r_in.resp_word3       <= i_in.resp_word3;
            r_in.data_first_word  <= i_in.data_first_word;
            r_in.data_eighth_word <= i_in.data_eighth_word;
            r_in.sector           <= i_in.sector;
            r_in.block_count      <= i_in.block_count;
        end
    end

    sdcs_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_adv),
        .i_item    (r_in),
        .i_wide_en (r_wide_en),
        .o_emit    (w_emit),
        .o_res     (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.cmd_index       = r_out.cmd_index;
    assign o_out.cmd_argument    = r_out.cmd_argument;
    assign o_out.resp_flags      = r_out.resp_flags;
    assign o_out.data_dir        = r_out.data_dir;
    assign o_out.xfer_blocks     = r_out.xfer_blocks;
    assign o_out.xfer_block_size = r_out.xfer_block_size;
    assign o_out.clock_choice    = r_out.clock_choice;
    assign o_out.bus_width_four  = r_out.bus_width_four;
    assign o_out.seq_status      = r_out.seq_status;
    assign o_out.card_kind       = r_out.card_kind;
    assign o_out.sector_total    = r_out.sector_total;

    // A consumed start always yields a CMD0 at identification clock
    `SDCS_ASSERT_NXT(a_start_cmd0, i_clk, i_rst_n, w_adv && r_in.kind == KIND_START, r_out_valid && r_out.cmd_index == 6'd0 && r_out.clock_choice == CLK_ID && r_out.card_kind == CARD_NONE)
    // Status results carry no command
    `SDCS_ASSERT_IMP(a_status_clean, i_clk, i_rst_n, r_out_valid && r_out.seq_status != STAT_CMD, r_out.cmd_index == 6'd0 && r_out.clock_choice == CLK_KEEP && r_out.data_dir == DIR_NONE)
    // A data phase always has a nonzero block count and size
    `SDCS_ASSERT_IMP(a_data_blocks, i_clk, i_rst_n, r_out_valid && r_out.data_dir != DIR_NONE, r_out.xfer_blocks != 16'd0 && r_out.xfer_block_size != 10'd0)

endmodule

FILE: rtl/sdcs_core.sv
// Sequencer state and next-command decision for one registered event.
// Depends on sdcs_pkg.
module sdcs_core
    import sdcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    input  logic      i_wide_en,
    output logic      o_emit,
    output t_out_item o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_card, n_card;
    logic [31:0] r_rca, n_rca;
    logic [31:0] r_sectors, n_sectors;
    logic        r_sw2, n_sw2;
    logic [31:0] r_psec, n_psec;
    logic [15:0] r_pblk, n_pblk;
    logic        r_pwr, n_pwr;
    logic        r_wide, n_wide;

    // CSD capacity decode (word1 = resp_word2, word2 = resp_word1)
    logic [11:0] w_sd_cs;
    logic [4:0]  w_sd_sh;
    logic [36:0] w_sd_val;
    logic [21:0] w_hc_cs;
    logic [32:0] w_hc_val;
    logic [31:0] w_csd_sectors;

    always_comb begin
        w_sd_cs  = {i_item.resp_word2[9:0], i_item.resp_word1[31:30]};
        w_sd_sh  = 5'({2'b0, i_item.resp_word1[17:15]} + 5'd2
                   + {1'b0, i_item.resp_word2[19:16]});
        w_sd_val = {24'b0, 13'({1'b0, w_sd_cs} + 13'd1)} << w_sd_sh;
        w_hc_cs  = {i_item.resp_word2[5:0], i_item.resp_word1[31:16]};
        w_hc_val = {23'({1'b0, w_hc_cs} + 23'd1), 10'b0};
        if (i_item.resp_word3[31:30] == 2'b00) begin
            w_csd_sectors = {4'b0, w_sd_val[36:9]};
        end else if (w_hc_val[32]) begin
            w_csd_sectors = 32'hffff_ffff;
        end else begin
            w_csd_sectors = w_hc_val[31:0];
        end
    end

    logic       w_switch_ok;
    logic [5:0] w_xfer_idx;
    assign w_switch_ok = (i_item.data_first_word[15:0] != 16'd0)
                       && (i_item.data_eighth_word[15:0] == 16'd0);
    assign w_xfer_idx = r_pwr ? ((r_pblk == 16'd1) ? 6'd24 : 6'd25)
                              : ((r_pblk == 16'd1) ? 6'd17 : 6'd18);

    // Next state and next command
    always_comb begin
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [3:0]  flg;
        logic [1:0]  dir;
        logic [15:0] blk;
        logic [9:0]  bsz;
        logic [1:0]  clk;
        logic [1:0]  st;
        logic        wide_step;
        logic [1:0]  wide_clk;
        n_phase = r_phase; n_card = r_card; n_rca = r_rca; n_sectors = r_sectors;
        n_sw2 = r_sw2; n_psec = r_psec; n_pblk = r_pblk; n_pwr = r_pwr;
        n_wide = r_wide;
        o_emit = 1'b1;
        idx = 6'd0; arg = 32'd0; flg = FLAGS_NONE; dir = DIR_NONE; blk = 16'd0;
        bsz = 10'd0; clk = CLK_KEEP; st = STAT_CMD;
        wide_step = 1'b0; wide_clk = CLK_KEEP;

        if (i_item.kind == KIND_START) begin
            n_card = CARD_NONE; n_rca = 32'd0; n_sectors = 32'd0; n_sw2 = 1'b0;
            n_wide = 1'b0; n_phase = PH_C0; clk = CLK_ID;
        end else if (i_item.kind != KIND_DONE) begin
            if (r_phase != PH_READY) begin
                st = STAT_FAIL;
            end else begin
                n_psec = i_item.sector;
                n_pblk = (i_item.block_count == 16'd0) ? 16'd1 : i_item.block_count;
                n_pwr  = (i_item.kind == KIND_WRITE);
                n_phase = PH_RSEL; idx = 6'd7; arg = r_rca; flg = FLAGS_BUSY;
            end
        end else begin
            case (r_phase)
                PH_C0: begin
                    n_phase = PH_C8; idx = 6'd8; arg = CMD8_ARG; flg = FLAGS_SHORT;
                end
                PH_C8: begin
                    if (i_item.cmd_ok) begin
                        n_phase = PH_H55; idx = 6'd55; flg = FLAGS_SHORT;
                    end else begin
                        n_phase = PH_L0;
                    end
                end
                PH_H55, PH_L41, PH_LL55, PH_H41: begin
                    if (r_phase == PH_H55 || r_phase == PH_LL55) begin
                        n_phase = PH_H41; idx = 6'd41; arg = ACMD41_ARG; flg = FLAGS_LONG;
                        if (r_phase == PH_LL55) n_phase = PH_L41;
                    end else if (!i_item.cmd_ok || !i_item.resp_word3[31]) begin
                        n_phase = (r_phase == PH_H41) ? PH_H55 : PH_LL55;
                        idx = 6'd55; flg = FLAGS_SHORT;
                    end else begin
                        n_card = (r_phase == PH_H41 && i_item.resp_word3[30])
                               ? CARD_SDHC : CARD_SDSC;
                        n_phase = PH_CID; idx = 6'd2; flg = FLAGS_LONG;
                    end
                end
                PH_L0: begin
                    n_phase = PH_L55; idx = 6'd55; flg = FLAGS_SHORT;
                end
                PH_L55: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_IDLE; st = STAT_FAIL;
                    end else begin
                        n_phase = PH_L41; idx = 6'd41; arg = ACMD41_ARG; flg = FLAGS_LONG;
                    end
                end
                PH_CID: begin
                    n_phase = PH_RCA; idx = 6'd3; flg = FLAGS_LONG;
                end
                PH_RCA: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_IDLE; st = STAT_FAIL;
                    end else begin
                        n_rca = i_item.resp_word3;
                        n_phase = PH_CSD; idx = 6'd9; arg = i_item.resp_word3;
                        flg = FLAGS_LONG;
                    end
                end
                PH_CSD: begin
                    n_sectors = w_csd_sectors;
                    n_phase = PH_SEL; idx = 6'd7; arg = r_rca; flg = FLAGS_SHORT;
                end
                PH_SEL: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else if (r_card == CARD_SDHC) begin
                        n_phase = PH_SCR55; idx = 6'd55; arg = r_rca; flg = FLAGS_SHORT;
                    end else begin
                        wide_step = 1'b1; wide_clk = CLK_HS;
                    end
                end
                PH_SCR55: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else begin
                        n_phase = PH_SCR; idx = 6'd51; flg = FLAGS_SHORT;
                        dir = DIR_READ; blk = 16'd1; bsz = 10'd8;
                    end
                end
                PH_SCR: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else if (i_item.data_first_word[3:0] == 4'h2) begin
                        n_sw2 = 1'b0; n_phase = PH_SW; idx = 6'd6; arg = SWITCH_ARG;
                        flg = FLAGS_SHORT; dir = DIR_READ; blk = 16'd1; bsz = 10'd64;
                    end else begin
                        wide_step = 1'b1;
                    end
                end
                PH_SW: begin
                    if (i_item.cmd_ok && w_switch_ok && !r_sw2) begin
                        n_sw2 = 1'b1; idx = 6'd6; arg = SWITCH_ARG;
                        flg = FLAGS_SHORT; dir = DIR_READ; blk = 16'd1; bsz = 10'd64;
                    end else begin
                        wide_step = 1'b1;
                        wide_clk = (i_item.cmd_ok && w_switch_ok) ? CLK_HS : CLK_KEEP;
                    end
                end
                PH_W55: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else begin
                        n_phase = PH_W6; idx = 6'd6; arg = 32'd2; flg = FLAGS_SHORT;
                    end
                end
                PH_W6: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else begin
                        n_wide = 1'b1; n_phase = PH_BLEN; idx = 6'd16;
                        arg = 32'(BLOCK_BYTES); flg = FLAGS_BUSY;
                    end
                end
                PH_BLEN: begin
                    n_phase = PH_DESEL; idx = 6'd7;
                end
                PH_DESEL, PH_RDESEL: begin
                    n_phase = PH_READY; st = i_item.cmd_ok ? STAT_OK : STAT_FAIL;
                end
                PH_RSEL: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else begin
                        n_phase = PH_XFER; idx = w_xfer_idx;
                        arg = (r_card == CARD_SDHC) ? r_psec : {r_psec[22:0], 9'b0};
                        flg = FLAGS_BUSY; dir = r_pwr ? DIR_WRITE : DIR_READ;
                        blk = r_pblk; bsz = 10'(BLOCK_BYTES);
                    end
                end
                PH_XFER: begin
                    if (!i_item.cmd_ok) begin
                        n_phase = PH_READY; st = STAT_FAIL;
                    end else begin
                        n_phase = PH_RDESEL; idx = 6'd7;
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end

        // Hand-off to the bus width step (ACMD6 or straight to CMD16)
        if (wide_step) begin
            clk = wide_clk;
            if (i_wide_en) begin
                n_phase = PH_W55; idx = 6'd55; arg = r_rca; flg = FLAGS_SHORT;
            end else begin
                n_phase = PH_BLEN; idx = 6'd16; arg = 32'(BLOCK_BYTES); flg = FLAGS_BUSY;
            end
        end

        o_res.cmd_index       = idx;
        o_res.cmd_argument    = arg;
        o_res.resp_flags      = flg;
        o_res.data_dir        = dir;
        o_res.xfer_blocks     = blk;
        o_res.xfer_block_size = bsz;
        o_res.clock_choice    = clk;
        o_res.bus_width_four  = n_wide;
        o_res.seq_status      = st;
        o_res.card_kind       = n_card;
        o_res.sector_total    = n_sectors;
    end

    // State registers, updated when an event is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_card <= CARD_NONE; r_rca <= 32'd0;
            r_sectors <= 32'd0; r_sw2 <= 1'b0; r_psec <= 32'd0;
            r_pblk <= 16'd0; r_pwr <= 1'b0; r_wide <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_card <= n_card; r_rca <= n_rca;
            r_sectors <= n_sectors; r_sw2 <= n_sw2; r_psec <= n_psec;
            r_pblk <= n_pblk; r_pwr <= n_pwr; r_wide <= n_wide;
        end
    end

endmodule

FILE: tb/tb_sd_card_init_and_transfer_sequencer_top.sv
// Testbench for the SD command sequencer top level: drives events, predicts the
// next command for each one, checks every result. Depends on sdcs_pkg, sdcs_if.
module tb_sd_card_init_and_transfer_sequencer_top;
    import sdcs_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic        cmd_ok;
        logic [31:0] w0, w1, w2, w3, d0, d7, sector;
        logic [15:0] cnt;
    } t_event;

    typedef struct {
        t_phase      phase;
        logic [1:0]  ctype;
        logic [31:0] rca;
        logic [31:0] sectors;
        logic        sw_second;
        logic [31:0] psec;
        logic [15:0] pblk;
        logic        pwr;
        logic        wide;
        logic        wide_en;
    } t_seq;

    logic i_clk;
    logic i_rst_n;
    sdcs_in_if  in_ch();
    sdcs_out_if out_ch();
    sdcs_cfg_if cfg_ch();

    sd_card_init_and_transfer_sequencer_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    t_event     event_q[$];
    t_event     cur_ev;
    t_out_item  cmd_exp_q[$];
    t_seq       gen_seq, chk_seq;
    int         mismatches = 0;
    int         cycles = 0;
    int         results_seen = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_cnt = 0;
    bit         hold_done = 0;
    bit         in_acc = 0;
    int         produced = 0;

    // Clock
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_out_item make_res(t_seq s, logic [5:0] idx, logic [31:0] arg,
                                           logic [3:0] flags, logic [1:0] dir,
                                           logic [15:0] blk, logic [9:0] size,
                                           logic [1:0] clk, logic [1:0] stat);
        t_out_item r;
        r.cmd_index       = idx;
        r.cmd_argument    = arg;
        r.resp_flags      = flags;
        r.data_dir        = dir;
        r.xfer_blocks     = blk;
        r.xfer_block_size = size;
        r.clock_choice    = clk;
        r.bus_width_four  = s.wide;
        r.seq_status      = stat;
        r.card_kind       = s.ctype;
        r.sector_total    = s.sectors;
        return r;
    endfunction

    // Bus width step after setup: ACMD6 path or straight to CMD16
    function automatic t_out_item width_step(inout t_seq s, input logic [1:0] clk);
        if (s.wide_en) begin
            s.phase = PH_W55;
            return make_res(s, 55, s.rca, FLAGS_SHORT, DIR_NONE, 0, 0, clk, STAT_CMD);
        end
        s.phase = PH_BLEN;
        return make_res(s, 16, BLOCK_BYTES, FLAGS_BUSY, DIR_NONE, 0, 0, clk, STAT_CMD);
    endfunction

    function automatic t_out_item fail_to(inout t_seq s, input t_phase nxt);
        s.phase = nxt;
        return make_res(s, 0, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP, STAT_FAIL);
    endfunction

    // Next-command predictor; has is cleared when the event gives no result
    function automatic t_out_item next_command(inout t_seq s, input t_event e,
                                               output bit has);
        logic [63:0] cs, v;
        logic [5:0]  sh;
        logic [5:0]  idx;
        logic [31:0] arg;
        has = 1;
        if (e.kind == KIND_START) begin
            s.ctype = CARD_NONE; s.rca = 0; s.sectors = 0; s.sw_second = 0; s.wide = 0;
            s.phase = PH_C0;
            return make_res(s, 0, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_ID, STAT_CMD);
        end
        if (e.kind == KIND_READ || e.kind == KIND_WRITE) begin
            if (s.phase != PH_READY)
                return make_res(s, 0, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP, STAT_FAIL);
            s.psec = e.sector;
            s.pblk = (e.cnt == 0) ? 16'd1 : e.cnt;
            s.pwr  = (e.kind == KIND_WRITE);
            s.phase = PH_RSEL;
            return make_res(s, 7, s.rca, FLAGS_BUSY, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
        end
        case (s.phase)
            PH_C0: begin
                s.phase = PH_C8;
                return make_res(s, 8, CMD8_ARG, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_C8: begin
                if (e.cmd_ok) begin
                    s.phase = PH_H55;
                    return make_res(s, 55, 0, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
                end
                s.phase = PH_L0;
                return make_res(s, 0, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_H55, PH_LL55: begin
                s.phase = (s.phase == PH_H55) ? PH_H41 : PH_L41;
                return make_res(s, 41, ACMD41_ARG, FLAGS_LONG, DIR_NONE, 0, 0, CLK_KEEP,
                                STAT_CMD);
            end
            PH_H41, PH_L41: begin
                if (!e.cmd_ok || !e.w3[31]) begin
                    s.phase = (s.phase == PH_H41) ? PH_H55 : PH_LL55;
                    return make_res(s, 55, 0, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
                end
                s.ctype = (s.phase == PH_H41 && e.w3[30]) ? CARD_SDHC : CARD_SDSC;
                s.phase = PH_CID;
                return make_res(s, 2, 0, FLAGS_LONG, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_L0: begin
                s.phase = PH_L55;
                return make_res(s, 55, 0, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_L55: begin
                if (!e.cmd_ok) return fail_to(s, PH_IDLE);
                s.phase = PH_L41;
                return make_res(s, 41, ACMD41_ARG, FLAGS_LONG, DIR_NONE, 0, 0, CLK_KEEP,
                                STAT_CMD);
            end
            PH_CID: begin
                s.phase = PH_RCA;
                return make_res(s, 3, 0, FLAGS_LONG, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_RCA: begin
                if (!e.cmd_ok) return fail_to(s, PH_IDLE);
                s.rca = e.w3;
                s.phase = PH_CSD;
                return make_res(s, 9, s.rca, FLAGS_LONG, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_CSD: begin
                // Capacity decode: word2 holds the upper CSD bits, word1 the lower
                if (e.w3[31:30] == 2'b00) begin
                    cs = {52'd0, e.w2[9:0], e.w1[31:30]};
                    sh = {3'd0, e.w1[17:15]} + 6'd2 + {2'd0, e.w2[19:16]};
                    v = ((cs + 64'd1) << sh) >> 9;
                    s.sectors = v[31:0];
                end else begin
                    cs = {42'd0, e.w2[5:0], e.w1[31:16]};
                    v = (cs + 64'd1) * 64'd1024;
                    s.sectors = (v > 64'hffff_ffff) ? 32'hffff_ffff : v[31:0];
                end
                s.phase = PH_SEL;
                return make_res(s, 7, s.rca, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_SEL: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                if (s.ctype == CARD_SDHC) begin
                    s.phase = PH_SCR55;
                    return make_res(s, 55, s.rca, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP,
                                    STAT_CMD);
                end
                return width_step(s, CLK_HS);
            end
            PH_SCR55: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                s.phase = PH_SCR;
                return make_res(s, 51, 0, FLAGS_SHORT, DIR_READ, 1, 8, CLK_KEEP, STAT_CMD);
            end
            PH_SCR: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                if (e.d0[3:0] == 4'h2) begin
                    s.sw_second = 0;
                    s.phase = PH_SW;
                    return make_res(s, 6, SWITCH_ARG, FLAGS_SHORT, DIR_READ, 1, 64, CLK_KEEP,
                                    STAT_CMD);
                end
                return width_step(s, CLK_KEEP);
            end
            PH_SW: begin
                // Switch check passes when function group bits are set and busy clear
                if (e.cmd_ok && e.d0[15:0] != 0 && e.d7[15:0] == 0) begin
                    if (!s.sw_second) begin
                        s.sw_second = 1;
                        return make_res(s, 6, SWITCH_ARG, FLAGS_SHORT, DIR_READ, 1, 64,
                                        CLK_KEEP, STAT_CMD);
                    end
                    return width_step(s, CLK_HS);
                end
                return width_step(s, CLK_KEEP);
            end
            PH_W55: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                s.phase = PH_W6;
                return make_res(s, 6, 2, FLAGS_SHORT, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_W6: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                s.wide = 1;
                s.phase = PH_BLEN;
                return make_res(s, 16, BLOCK_BYTES, FLAGS_BUSY, DIR_NONE, 0, 0, CLK_KEEP,
                                STAT_CMD);
            end
            PH_BLEN: begin
                s.phase = PH_DESEL;
                return make_res(s, 7, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            PH_DESEL, PH_RDESEL: begin
                s.phase = PH_READY;
                return make_res(s, 0, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP,
                                e.cmd_ok ? STAT_OK : STAT_FAIL);
            end
            PH_RSEL: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                if (s.pwr) idx = (s.pblk == 1) ? 6'd24 : 6'd25;
                else       idx = (s.pblk == 1) ? 6'd17 : 6'd18;
                arg = (s.ctype == CARD_SDHC) ? s.psec : (s.psec << 9);
                s.phase = PH_XFER;
                return make_res(s, idx, arg, FLAGS_BUSY, s.pwr ? DIR_WRITE : DIR_READ, s.pblk,
                                BLOCK_BYTES, CLK_KEEP, STAT_CMD);
            end
            PH_XFER: begin
                if (!e.cmd_ok) return fail_to(s, PH_READY);
                s.phase = PH_RDESEL;
                return make_res(s, 7, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
            default: begin
                // completion while idle or ready
                has = 0;
                return make_res(s, 0, 0, FLAGS_NONE, DIR_NONE, 0, 0, CLK_KEEP, STAT_CMD);
            end
        endcase
    endfunction

    // Queue an event and track where the sequence will be
    task automatic queue_event(input t_event e);
        bit has;
        t_out_item dummy;
        dummy = next_command(gen_seq, e, has);
        if (has) produced++;
        event_q.push_back(e);
    endtask

    task automatic directed(input logic [1:0] k, input logic ok, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3,
                            input logic [31:0] d0, input logic [31:0] d7,
                            input logic [31:0] sec, input logic [15:0] cnt);
        t_event e;
        e.kind = k; e.cmd_ok = ok; e.w0 = $urandom; e.w1 = w1; e.w2 = w2; e.w3 = w3;
        e.d0 = d0; e.d7 = d7; e.sector = sec; e.cnt = cnt;
        queue_event(e);
    endtask

    // Random event steered by the tracked phase: mostly well-formed progress
    task automatic random_event();
        t_event e;
        int r;
        r = $urandom_range(0, 99);
        e.cmd_ok = ($urandom_range(0, 11) != 0);
        e.w0 = $urandom; e.w1 = $urandom; e.w2 = $urandom; e.w3 = $urandom;
        e.d0 = $urandom; e.d7 = $urandom; e.sector = $urandom;
        if ($urandom_range(0, 3) != 0) e.w3[31] = 1'b1;
        if ($urandom_range(0, 9) < 7) e.d0[3:0] = 4'h2;
        if ($urandom_range(0, 19) == 0) e.d0[15:0] = 16'd0;
        if ($urandom_range(0, 9) < 7) e.d7[15:0] = 16'd0;
        case ($urandom_range(0, 9))
            0:       e.cnt = 16'd0;
            1:       e.cnt = 16'hffff;
            2:       e.cnt = 16'($urandom);
            default: e.cnt = 16'($urandom_range(1, 4));
        endcase
        if (gen_seq.phase == PH_IDLE)
            e.kind = (r < 85) ? KIND_START : (r < 93) ? KIND_DONE
                   : ($urandom_range(0, 1) ? KIND_READ : KIND_WRITE);
        else if (gen_seq.phase == PH_READY)
            e.kind = (r < 80) ? ($urandom_range(0, 1) ? KIND_READ : KIND_WRITE)
                   : (r < 88) ? KIND_START : KIND_DONE;
        else
            e.kind = (r < 93) ? KIND_DONE : (r < 96) ? KIND_START
                   : ($urandom_range(0, 1) ? KIND_READ : KIND_WRITE);
        queue_event(e);
    endtask

    // Wait until every event is sent and every result is back
    task automatic drain();
        while (event_q.size() != 0 || in_ch.valid || cmd_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_wide_enable(input logic val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        gen_seq.wide_en = val;
        chk_seq.wide_en = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Input driver: one transaction at a time with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_acc) begin
            if (send_gap > 0 || event_q.size() == 0) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else begin
                cur_ev = event_q.pop_front();
                in_ch.valid            <= 1'b1;
                in_ch.kind             <= cur_ev.kind;
                in_ch.cmd_ok           <= cur_ev.cmd_ok;
                in_ch.resp_word0       <= cur_ev.w0;
                in_ch.resp_word1       <= cur_ev.w1;
                in_ch.resp_word2       <= cur_ev.w2;
                in_ch.resp_word3       <= cur_ev.w3;
                in_ch.data_first_word  <= cur_ev.d0;
                in_ch.data_eighth_word <= cur_ev.d7;
                in_ch.sector           <= cur_ev.sector;
                in_ch.block_count      <= cur_ev.cnt;
                send_gap <= pick_gap();
            end
        end
    end

    // Accepted input transaction: predict its result
    always @(posedge i_clk) begin
        t_event e;
        t_out_item r;
        bit has;
        in_acc <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            e.kind = in_ch.kind; e.cmd_ok = in_ch.cmd_ok; e.w0 = in_ch.resp_word0;
            e.w1 = in_ch.resp_word1; e.w2 = in_ch.resp_word2; e.w3 = in_ch.resp_word3;
            e.d0 = in_ch.data_first_word; e.d7 = in_ch.data_eighth_word;
            e.sector = in_ch.sector; e.cnt = in_ch.block_count;
            r = next_command(chk_seq, e, has);
            if (has) cmd_exp_q.push_back(r);
        end
    end

    // Receiver ready: random gaps plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done <= 1'b1;
            hold_cnt  <= 200;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            recv_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen <= results_seen + 1;
            got.cmd_index       = out_ch.cmd_index;
            got.cmd_argument    = out_ch.cmd_argument;
            got.resp_flags      = out_ch.resp_flags;
            got.data_dir        = out_ch.data_dir;
            got.xfer_blocks     = out_ch.xfer_blocks;
            got.xfer_block_size = out_ch.xfer_block_size;
            got.clock_choice    = out_ch.clock_choice;
            got.bus_width_four  = out_ch.bus_width_four;
            got.seq_status      = out_ch.seq_status;
            got.card_kind       = out_ch.card_kind;
            got.sector_total    = out_ch.sector_total;
            if (cmd_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = cmd_exp_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("tb_sd_card_init_and_transfer_sequencer_top: errors");
            $finish;
        end
    end

    // Stimulus: directed walk, then random phases at several register settings
    initial begin
        in_ch.kind = KIND_START; in_ch.cmd_ok = 0;
        in_ch.resp_word0 = 0; in_ch.resp_word1 = 0; in_ch.resp_word2 = 0;
        in_ch.resp_word3 = 0; in_ch.data_first_word = 0; in_ch.data_eighth_word = 0;
        in_ch.sector = 0; in_ch.block_count = 0;
        cfg_ch.valid = 0; cfg_ch.data = 0;
        gen_seq = '{PH_IDLE, CARD_NONE, 0, 0, 0, 0, 0, 0, 0, 1};
        chk_seq = gen_seq;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Request and completion before any start
        directed(KIND_READ, 1, 0, 0, 0, 0, 0, 5, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        // SDSC path: CMD8 fails, ACMD41 busy once, full-width setup
        directed(KIND_START, 0, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 32'h0000_0000, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 32'hffff_ffff, 0, 0, 0, 1);
        directed(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 32'hffff_ffff, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        // Zero block count read, then a maximal write at the last sector
        directed(KIND_READ, 1, 0, 0, 0, 0, 0, 32'hffff_ffff, 0);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
        directed(KIND_WRITE, 1, 0, 0, 0, 0, 0, 32'hffff_ffff, 16'hffff);
        directed(KIND_DONE, 1, 0, 0, 0, 0, 0, 0, 1);
        drain();

        write_wide_enable(1'b0);
        while (produced < 450) random_event();
        drain();
        write_wide_enable(1'b1);
        while (produced < 850) random_event();
        drain();
        write_wide_enable(1'b0);
        while (produced < 1170) random_event();
        drain();

        if (mismatches == 0 && cmd_exp_q.size() == 0) begin
            $display("tb_sd_card_init_and_transfer_sequencer_top: clean");
        end else begin
            $display("tb_sd_card_init_and_transfer_sequencer_top: errors");
        end
        $finish;
    end
endmodule
